/* rtl/core/spq_pkg.sv */
// Package for the sorted priority queue: operation codes, field widths,
// item and result structs, and the stored slot layout. No dependencies.
package spq_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int PRIO_W       = 8;
  localparam int PAYLOAD_W    = 64;
  localparam int COUNT_OUT_W  = 5;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_DELETE = 2'd1;
  localparam logic [1:0] FUNC_DUMP   = 2'd2;
  localparam logic [1:0] FUNC_CLEAR  = 2'd3;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_DROPPED = 1'b1;

  typedef struct packed {
    logic [1:0]           func;
    logic [PRIO_W-1:0]    priority_req;
    logic [PAYLOAD_W-1:0] payload;
  } cmd_t;

  typedef struct packed {
    logic                   status;
    logic                   entry_valid;
    logic [PRIO_W-1:0]      entry_priority;
    logic [PAYLOAD_W-1:0]   entry_payload;
    logic [COUNT_OUT_W-1:0] removed_count;
    logic [COUNT_OUT_W-1:0] occupancy;
    logic                   last;
  } res_t;

  typedef struct packed {
    logic [PRIO_W-1:0]    prio;
    logic [PAYLOAD_W-1:0] payload;
  } slot_t;

  function automatic res_t make_res(input logic                   status,
                                    input logic                   entry_valid,
                                    input logic [PRIO_W-1:0]      entry_priority,
                                    input logic [PAYLOAD_W-1:0]   entry_payload,
                                    input logic [COUNT_OUT_W-1:0] removed_count,
                                    input logic [COUNT_OUT_W-1:0] occupancy,
                                    input logic                   last);
    res_t r;
    r.status         = status;
    r.entry_valid    = entry_valid;
    r.entry_priority = entry_priority;
    r.entry_payload  = entry_payload;
    r.removed_count  = removed_count;
    r.occupancy      = occupancy;
    r.last           = last;
    return r;
  endfunction

endpackage

/* rtl/core/spq_mem.sv */
// Slot store of the sorted priority queue: one write port, one read port,
// read data registered. Depends on spq_pkg for the slot layout.
module spq_mem #(
  parameter int DEPTH  = spq_pkg::CAPACITY_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                we,
  input  logic [ADDR_W-1:0]   waddr,
  input  spq_pkg::slot_t      wdata,
  input  logic [ADDR_W-1:0]   raddr,
  output spq_pkg::slot_t      rdata
);

  spq_pkg::slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/spq_ctrl.sv */
// Sequencer of the sorted priority queue: walks the slot store for insert,
// delete and dump, and holds the entry count. Depends on spq_pkg.
module spq_ctrl #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF,
  parameter int ADDR_W   = $clog2(CAPACITY),
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  spq_pkg::cmd_t       cmd,
  output spq_pkg::res_t       result,
  output logic                result_valid,
  output logic                we,
  output logic [ADDR_W-1:0]   waddr,
  output spq_pkg::slot_t      wdata,
  output logic [ADDR_W-1:0]   raddr,
  input  spq_pkg::slot_t      rdata
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS_RD  = 3'd1;
  localparam logic [2:0] S_INS_CMP = 3'd2;
  localparam logic [2:0] S_DEL_RD  = 3'd3;
  localparam logic [2:0] S_DEL_CMP = 3'd4;
  localparam logic [2:0] S_DMP_RD  = 3'd5;
  localparam logic [2:0] S_DMP_OUT = 3'd6;

  localparam logic [spq_pkg::COUNT_OUT_W-1:0] ZERO5 = '0;

  logic [2:0]                     state;
  logic [CNT_W-1:0]               count;
  logic [CNT_W-1:0]               idx;
  logic [CNT_W-1:0]               wr;
  logic [spq_pkg::PRIO_W-1:0]     key;
  logic [spq_pkg::PAYLOAD_W-1:0]  new_payload;

  logic [CNT_W-1:0] idx_dec;
  logic [CNT_W-1:0] idx_inc;
  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] wr_next;
  logic             keep;
  spq_pkg::slot_t   new_slot;

  function automatic logic [spq_pkg::COUNT_OUT_W-1:0] fit5(input logic [CNT_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[spq_pkg::COUNT_OUT_W-1:0];
  endfunction

  assign busy      = (state != S_IDLE);
  assign idx_dec   = CNT_W'(idx - 1'b1);
  assign idx_inc   = CNT_W'(idx + 1'b1);
  assign count_inc = CNT_W'(count + 1'b1);
  assign keep      = (rdata.prio != key);
  assign wr_next   = keep ? CNT_W'(wr + 1'b1) : wr;
  assign new_slot  = '{prio: key, payload: new_payload};

  // Memory port control.
  always_comb begin
    we    = 1'b0;
    waddr = idx[ADDR_W-1:0];
    wdata = new_slot;
    raddr = idx[ADDR_W-1:0];
    case (state)
      S_INS_RD: begin
        raddr = idx_dec[ADDR_W-1:0];
        we    = (idx == '0);
      end
      S_INS_CMP: begin
        // Larger priorities move up one slot; the new entry lands above
        // the first entry that is not larger.
        we    = 1'b1;
        wdata = (rdata.prio > key) ? rdata : new_slot;
      end
      S_DEL_CMP: begin
        we    = keep;
        waddr = wr[ADDR_W-1:0];
        wdata = rdata;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            key         <= cmd.priority_req;
            new_payload <= cmd.payload;
            // Insert walks down from the top entry, the others up from slot zero.
            idx         <= (cmd.func == spq_pkg::FUNC_INSERT) ? count : '0;
            wr          <= '0;
            case (cmd.func)
              spq_pkg::FUNC_INSERT: begin
                if (count >= CNT_W'(CAPACITY)) begin
                  result_valid <= 1'b1;
                  result <= spq_pkg::make_res(spq_pkg::STATUS_DROPPED, 1'b0, '0, '0,
                                              ZERO5, fit5(count), 1'b1);
                end else begin
                  result_valid <= 1'b0;
                  state        <= S_INS_RD;
                end
              end
              spq_pkg::FUNC_DELETE: begin
                if (count == '0) begin
                  result_valid <= 1'b1;
                  result <= spq_pkg::make_res(spq_pkg::STATUS_OK, 1'b0, '0, '0,
                                              ZERO5, ZERO5, 1'b1);
                end else begin
                  result_valid <= 1'b0;
                  state        <= S_DEL_RD;
                end
              end
              spq_pkg::FUNC_DUMP: begin
                if (count == '0) begin
                  result_valid <= 1'b1;
                  result <= spq_pkg::make_res(spq_pkg::STATUS_OK, 1'b0, '0, '0,
                                              ZERO5, ZERO5, 1'b1);
                end else begin
                  result_valid <= 1'b0;
                  state        <= S_DMP_RD;
                end
              end
              default: begin
                count        <= '0;
                result_valid <= 1'b1;
                result <= spq_pkg::make_res(spq_pkg::STATUS_OK, 1'b0, '0, '0,
                                            ZERO5, ZERO5, 1'b1);
              end
            endcase
          end else begin
            result_valid <= 1'b0;
          end
        end
        S_INS_RD: begin
          if (idx == '0) begin
            count        <= count_inc;
            result_valid <= 1'b1;
            result <= spq_pkg::make_res(spq_pkg::STATUS_OK, 1'b0, '0, '0,
                                        ZERO5, fit5(count_inc), 1'b1);
            state        <= S_IDLE;
          end else begin
            result_valid <= 1'b0;
            state        <= S_INS_CMP;
          end
        end
        S_INS_CMP: begin
          if (rdata.prio > key) begin
            result_valid <= 1'b0;
            idx          <= idx_dec;
            state        <= S_INS_RD;
          end else begin
            count        <= count_inc;
            result_valid <= 1'b1;
            result <= spq_pkg::make_res(spq_pkg::STATUS_OK, 1'b0, '0, '0,
                                        ZERO5, fit5(count_inc), 1'b1);
            state        <= S_IDLE;
          end
        end
        S_DEL_RD: begin
          result_valid <= 1'b0;
          state        <= S_DEL_CMP;
        end
        S_DEL_CMP: begin
          wr <= wr_next;
          if (idx_inc == count) begin
            count        <= wr_next;
            result_valid <= 1'b1;
            result <= spq_pkg::make_res(spq_pkg::STATUS_OK, 1'b0, '0, '0,
                                        fit5(CNT_W'(count - wr_next)),
                                        fit5(wr_next), 1'b1);
            state        <= S_IDLE;
          end else begin
            result_valid <= 1'b0;
            idx          <= idx_inc;
            state        <= S_DEL_RD;
          end
        end
        S_DMP_RD: begin
          result_valid <= 1'b0;
          state        <= S_DMP_OUT;
        end
        S_DMP_OUT: begin
          result_valid <= 1'b1;
          result <= spq_pkg::make_res(spq_pkg::STATUS_OK, 1'b1, rdata.prio, rdata.payload,
                                      ZERO5, fit5(count), idx_inc == count);
          if (idx_inc == count) begin
            state <= S_IDLE;
          end else begin
            idx   <= idx_inc;
            state <= S_DMP_RD;
          end
        end
        default: begin
          result_valid <= 1'b0;
          state        <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/sorted_priority_queue.sv */
// Insert walks the slot store from the top entry down, and delete and dump walk it
// up from slot zero; dump gives one result per entry held, the last one marked last.
// Full insert, clear and empty delete or dump answer straight from the idle state. busy
// stays high until the cycle that shows the item's last result, and the next item can
// be taken at the end of that cycle; the receiver cannot stall results. Synchronous
// reset empties the queue and idles the sequencer; it does not clear the slot store.
// Top level of the sorted priority queue. Depends on spq_pkg, spq_mem and
// spq_ctrl.
module sorted_priority_queue #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  spq_pkg::cmd_t cmd,
  output spq_pkg::res_t result,
  output logic          result_valid
);

  // Entries live in a single slot store: the sequencer issues a read, then
  // acts on the registered data. Data read from slots above the entry count is
  // never used, so the store needs no clearing.
  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  spq_pkg::slot_t    wdata;
  spq_pkg::slot_t    rdata;

  // Insert walks down from the top entry, moving each larger priority up by
  // one slot, so equal priorities keep their arrival order. Delete compacts
  // the kept entries towards slot zero; the write pointer never passes the
  // read pointer, so no forwarding is needed.
  spq_ctrl #(
    .CAPACITY (CAPACITY),
    .ADDR_W   (ADDR_W),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result       (result),
    .result_valid (result_valid),
    .we           (we),
    .waddr        (waddr),
    .wdata        (wdata),
    .raddr        (raddr),
    .rdata        (rdata)
  );

  spq_mem #(
    .DEPTH  (CAPACITY),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule

/* rtl/core/spq_checker.sv */
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue.
module spq_checker #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEF
) (
  input logic          clk,
  input logic          rst,
  input logic          start,
  input logic          busy,
  input spq_pkg::res_t result,
  input logic          result_valid
);

  a_result_has_cause: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy || start))
    else $error("result with no item in progress");

  a_last_ends_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.last == !busy))
    else $error("last flag disagrees with busy");

  a_plain_result_is_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.entry_valid) |-> result.last)
    else $error("non-entry result not marked last");

  a_drop_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status) |->
      (result.occupancy == spq_pkg::COUNT_OUT_W'(CAPACITY)))
    else $error("insert dropped while queue not full");

  a_occupancy_bound: assert property (@(posedge clk) disable iff (rst)
    (result_valid && (CAPACITY < 32)) |->
      (32'(result.occupancy) <= 32'(CAPACITY)))
    else $error("occupancy above capacity");

endmodule

bind sorted_priority_queue spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result       (result),
  .result_valid (result_valid)
);

/* verif/sorted_priority_queue_tb.sv */
// Self-checking testbench for sorted_priority_queue: directed corner items, then random
// phases with sender gaps, each result checked against a shadow of the queue contents.
// Depends on spq_pkg and the sorted_priority_queue RTL.
`timescale 1ns / 1ps

// Shadow of the queue contents. It works out the results that each accepted item should
// produce and checks the block's results against them in order.
class queue_shadow;
  spq_pkg::slot_t held[$];
  spq_pkg::res_t  awaited[$];
  int             capacity;
  int             errors;

  function new(int cap);
    capacity = cap;
    errors   = 0;
  endfunction

  // A result with no dumped entry, showing the occupancy after the operation.
  function spq_pkg::res_t bare_result(logic status, int removed);
    spq_pkg::res_t r;
    r                = '0;
    r.status         = status;
    r.removed_count  = removed[4:0];
    r.occupancy      = spq_pkg::COUNT_OUT_W'(held.size());
    r.last           = 1'b1;
    return r;
  endfunction

  function void note_item(spq_pkg::cmd_t c);
    spq_pkg::slot_t kept[$];
    spq_pkg::slot_t s;
    spq_pkg::res_t  r;
    int             pos;
    int             gone;
    case (c.func)
      spq_pkg::FUNC_INSERT: begin
        if (held.size() >= capacity) begin
          awaited.push_back(bare_result(spq_pkg::STATUS_DROPPED, 0));
        end else begin
          // A new entry goes behind every entry of equal or lower priority.
          pos = 0;
          while (pos < held.size() && held[pos].prio <= c.priority_req) pos++;
          s.prio    = c.priority_req;
          s.payload = c.payload;
          held.insert(pos, s);
          awaited.push_back(bare_result(spq_pkg::STATUS_OK, 0));
        end
      end
      spq_pkg::FUNC_DELETE: begin
        foreach (held[i]) if (held[i].prio != c.priority_req) kept.push_back(held[i]);
        gone = held.size() - kept.size();
        held = kept;
        awaited.push_back(bare_result(spq_pkg::STATUS_OK, gone));
      end
      spq_pkg::FUNC_DUMP: begin
        if (held.size() == 0) begin
          awaited.push_back(bare_result(spq_pkg::STATUS_OK, 0));
        end else begin
          foreach (held[i]) begin
            r                = '0;
            r.entry_valid    = 1'b1;
            r.entry_priority = held[i].prio;
            r.entry_payload  = held[i].payload;
            r.occupancy      = spq_pkg::COUNT_OUT_W'(held.size());
            r.last           = (i == held.size() - 1);
            awaited.push_back(r);
          end
        end
      end
      default: begin
        held.delete();
        awaited.push_back(bare_result(spq_pkg::STATUS_OK, 0));
      end
    endcase
  endfunction

  task report(string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  task compare_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
  endtask

  task check_result(spq_pkg::res_t got);
    spq_pkg::res_t want;
    if (awaited.size() == 0) begin
      report($sformatf("result %h arrived with nothing awaited", got));
      return;
    end
    want = awaited.pop_front();
    compare_field("status", 64'(got.status), 64'(want.status));
    compare_field("entry_valid", 64'(got.entry_valid), 64'(want.entry_valid));
    compare_field("entry_priority", 64'(got.entry_priority), 64'(want.entry_priority));
    compare_field("entry_payload", got.entry_payload, want.entry_payload);
    compare_field("removed_count", 64'(got.removed_count), 64'(want.removed_count));
    compare_field("occupancy", 64'(got.occupancy), 64'(want.occupancy));
    compare_field("last", 64'(got.last), 64'(want.last));
  endtask
endclass

module sorted_priority_queue_tb;

  localparam int CAP   = spq_pkg::CAPACITY_DEF;
  localparam int CMD_W = $bits(spq_pkg::cmd_t);

  // Every input of the block holds a known value from time zero.
  logic           clk   = 1'b0;
  logic           rst   = 1'b1;
  logic           start = 1'b0;
  logic           busy;
  spq_pkg::cmd_t  cmd   = '0;
  spq_pkg::res_t  result;
  logic           result_valid;

  // Chance, in percent, that the sender leaves a gap before the next item.
  int    idle_pct = 0;

  queue_shadow shadow = new(CAP);

  sorted_priority_queue #(.CAPACITY(CAP)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .result       (result),
    .result_valid (result_valid)
  );

  // 20 ns clock, high and low for 10 ns each.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Results are sampled at the rising edge. The receiver cannot hold them off, so every
  // strobed result is checked against the oldest awaited one.
  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1) shadow.check_result(result);
  end

  // Gap on the sender side: start is held low for a gap set by n, and the command bus
  // carries rubbish meanwhile so that the block cannot lean on a stale value.
  task automatic hold_off(input int n);
    @(negedge clk);
    start = 1'b0;
    cmd   = CMD_W'({$urandom, $urandom, $urandom});
    repeat (n - 1) @(negedge clk);
  endtask

  // Presents one item at the falling edge and holds it until the block takes it, that
  // is a rising edge with busy low. The shadow notes the item at that same edge.
  task automatic issue(input spq_pkg::cmd_t c);
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) hold_off($urandom_range(1, 40));
    @(negedge clk);
    start = 1'b1;
    cmd   = c;
    do @(posedge clk); while (busy !== 1'b0);
    shadow.note_item(c);
  endtask

  task automatic issue_fields(input logic [1:0] f, input logic [7:0] p, input logic [63:0] d);
    spq_pkg::cmd_t c;
    c.func         = f;
    c.priority_req = p;
    c.payload      = d;
    issue(c);
  endtask

  // The sender stops until every awaited result has come back.
  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (shadow.awaited.size() != 0) @(posedge clk);
  endtask

  initial begin
    spq_pkg::cmd_t c;
    int            roll;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part. An empty queue first: dump gives a single result with no entry,
    // delete finds nothing and clear changes nothing.
    issue_fields(spq_pkg::FUNC_DUMP, 8'd0, 64'd0);
    issue_fields(spq_pkg::FUNC_DELETE, 8'd42, 64'd0);
    issue_fields(spq_pkg::FUNC_CLEAR, 8'd0, 64'd0);
    // Priority and payload extremes, inserted so that the second one lands in front.
    issue_fields(spq_pkg::FUNC_INSERT, 8'hFF, '1);
    issue_fields(spq_pkg::FUNC_INSERT, 8'h00, 64'd0);
    // Three equal priorities must come out in the order in which they went in.
    for (int k = 0; k < 3; k++) begin
      issue_fields(spq_pkg::FUNC_INSERT, 8'd7, 64'hA5A5_5A5A_0F0F_F0F0 + k);
    end
    issue_fields(spq_pkg::FUNC_DUMP, 8'd0, 64'd0);
    issue_fields(spq_pkg::FUNC_DELETE, 8'd7, 64'd0);
    // Fill the queue up, then one more insert that must be dropped and flagged.
    while (shadow.held.size() < CAP) begin
      issue_fields(spq_pkg::FUNC_INSERT, 8'($urandom_range(0, 3)), {$urandom, $urandom});
    end
    issue_fields(spq_pkg::FUNC_INSERT, 8'd1, {$urandom, $urandom});
    issue_fields(spq_pkg::FUNC_DUMP, 8'd0, 64'd0);
    issue_fields(spq_pkg::FUNC_CLEAR, 8'd0, 64'd0);
    drain();

    // Random part in four phases: back to back, sender idle about half the time, back to
    // back again, and sender idle about a quarter of the time. Random gaps reach past the
    // longest insert, delete or dump, so they land on every stage of one.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        1:       idle_pct = 51;
        3:       idle_pct = 26;
        default: idle_pct = 0;
      endcase
      for (int k = 0; k < 101; k++) begin
        c.payload = {$urandom, $urandom};
        roll      = $urandom_range(0, 99);
        if (roll < 3) c.payload = '0;
        else if (roll < 6) c.payload = '1;
        // Mostly a few small priorities, so that runs of equal priority build up.
        roll = $urandom_range(0, 99);
        if (roll < 60) c.priority_req = 8'($urandom_range(0, 7));
        else if (roll < 70) c.priority_req = (roll < 65) ? 8'h00 : 8'hFF;
        else c.priority_req = 8'($urandom_range(0, 255));
        roll = $urandom_range(0, 99);
        if (roll < 58) begin
          c.func = spq_pkg::FUNC_INSERT;
        end else if (roll < 72) begin
          c.func = spq_pkg::FUNC_DELETE;
          // Most deletes aim at a priority that is actually held.
          if (shadow.held.size() != 0 && $urandom_range(0, 3) != 0) begin
            c.priority_req = shadow.held[$urandom_range(0, shadow.held.size() - 1)].prio;
          end
        end else if (roll < 96) begin
          c.func = spq_pkg::FUNC_DUMP;
        end else begin
          c.func = spq_pkg::FUNC_CLEAR;
        end
        issue(c);
        if ($urandom_range(0, 49) == 0) drain();
      end
      drain();
    end

    // Everything is back; allow for a stray late result before giving the verdict.
    repeat (40) @(posedge clk);
    if (shadow.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* files.f */
rtl/core/spq_pkg.sv
rtl/core/spq_mem.sv
rtl/core/spq_ctrl.sv
rtl/core/sorted_priority_queue.sv
rtl/core/spq_checker.sv
verif/sorted_priority_queue_tb.sv
